// ===== rtl/rtp_jpeg_frame_reassembly_tracker_unit_assert.svh =====
// assertion macros for the rtp/jpeg frame tracker
// included by the modules that carry concurrent checks; no other dependencies
`ifndef RTP_JPEG_FRAME_REASSEMBLY_TRACKER_UNIT_ASSERT_SVH
`define RTP_JPEG_FRAME_REASSEMBLY_TRACKER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define RJFRT_ASSERT_IMP(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("rjfrt same-cycle check failed");
// next-cycle implication
`define RJFRT_ASSERT_NXT(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("rjfrt next-cycle check failed");
`else
`define RJFRT_ASSERT_IMP(label, clk, rstn, pre, post)
`define RJFRT_ASSERT_NXT(label, clk, rstn, pre, post)
`endif
`endif

// ===== rtl/rjfrt_pkg.sv =====
// shared types and constants for the rtp/jpeg frame tracker
// no dependencies
package rjfrt_pkg;

    // parameter defaults
    localparam int FRAME_BUFFER_BYTES_DEF = 1048576;
    localparam int MAX_PACKET_BYTES_DEF   = 2048;

    // protocol constants
    localparam logic [6:0] JPEG_PT          = 7'h1A;
    localparam int         BASE_HDR         = 20;   // rtp 12 + jpeg 8
    localparam int         QHDR_BYTES       = 4;
    localparam int         QTABLE_MAX       = 128;
    localparam int         QUALITY_DYN_MIN  = 127;  // q above this carries tables
    localparam logic [16:0] COUNT_MAX       = 17'h1FFFF;
    localparam logic [20:0] TOTAL_MAX       = 21'h1FFFFF;

    typedef enum logic [2:0] {
        ST_ACCEPTED    = 3'd0,
        ST_NOT_FIRST   = 3'd1,
        ST_TABLE_LONG  = 3'd2,
        ST_TS_MISMATCH = 3'd3,
        ST_NOT_JPEG    = 3'd4,
        ST_TOO_SHORT   = 3'd5,
        ST_OVERFLOW    = 3'd6
    } status_t;

    // classified packet, front to back
    typedef struct packed {
        logic [23:0] frag_offset;
        logic [15:0] seq_number;
        logic [31:0] rtp_timestamp;
        logic        marker;
        logic        off_nonzero;
        logic        table_long;
        logic        not_jpeg;
        logic        short_first;
        logic        short_cont;
        logic        ovf_first;
        logic        ovf_cont;
        logic [11:0] pay_first;
        logic [11:0] pay_cont;
    } pkt_info_t;

endpackage

// ===== rtl/rjfrt_front.sv =====
// front stage: accepts a packet header word and precomputes every
// state-independent check; depends on rjfrt_pkg
module rjfrt_front #(
    parameter int FRAME_BUFFER_BYTES = rjfrt_pkg::FRAME_BUFFER_BYTES_DEF,
    parameter int MAX_PACKET_BYTES   = rjfrt_pkg::MAX_PACKET_BYTES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [23:0]          s_frag_offset,
    input  logic [7:0]           s_quality,
    input  logic [15:0]          s_table_length,
    input  logic [15:0]          s_seq_number,
    input  logic [31:0]          s_rtp_timestamp,
    input  logic [6:0]           s_payload_type,
    input  logic                 s_marker,
    input  logic [11:0]          s_packet_len,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rjfrt_pkg::pkt_info_t out_info
);

    localparam logic [16:0] MaxPkt = 17'(MAX_PACKET_BYTES);
    localparam logic [24:0] FrameBuf = 25'(FRAME_BUFFER_BYTES);

    logic                 valid_reg;
    rjfrt_pkg::pkt_info_t info_reg;
    rjfrt_pkg::pkt_info_t info_next;
    logic [11:0]          plen;
    logic [16:0]          hdr_first;
    logic [24:0]          end_cont;

    assign s_ready   = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_info  = info_reg;

    // classification of one word
    always_comb begin
        // receive buffer truncates long packets
        plen = ({5'b0, s_packet_len} > MaxPkt) ? MaxPkt[11:0] : s_packet_len;
        hdr_first = (s_quality > 8'(rjfrt_pkg::QUALITY_DYN_MIN)) ?
            17'(rjfrt_pkg::BASE_HDR + rjfrt_pkg::QHDR_BYTES) + {1'b0, s_table_length} :
            17'(rjfrt_pkg::BASE_HDR);

        info_next.frag_offset   = s_frag_offset;
        info_next.seq_number    = s_seq_number;
        info_next.rtp_timestamp = s_rtp_timestamp;
        info_next.marker        = s_marker;
        info_next.off_nonzero   = (s_frag_offset != 24'd0);
        info_next.table_long    = (s_quality > 8'(rjfrt_pkg::QUALITY_DYN_MIN)) &&
                                  (s_table_length > 16'(rjfrt_pkg::QTABLE_MAX));
        info_next.not_jpeg      = (s_payload_type != rjfrt_pkg::JPEG_PT);
        info_next.short_first   = ({5'b0, plen} < hdr_first);
        info_next.short_cont    = (plen < 12'(rjfrt_pkg::BASE_HDR));
        info_next.pay_first     = plen - hdr_first[11:0];
        info_next.pay_cont      = plen - 12'(rjfrt_pkg::BASE_HDR);
        // first packet always sits at offset zero
        info_next.ovf_first     = ({13'b0, info_next.pay_first} >= FrameBuf);
        end_cont                = {1'b0, s_frag_offset} + {13'b0, info_next.pay_cont};
        info_next.ovf_cont      = (end_cont >= FrameBuf);
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            info_reg <= info_next;
        end
    end

endmodule

// ===== rtl/rjfrt_queue.sv =====
// two-entry queue between front and back stages
// depends on rjfrt_pkg and the assertion header
`include "rtp_jpeg_frame_reassembly_tracker_unit_assert.svh"
module rjfrt_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  rjfrt_pkg::pkt_info_t in_info,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rjfrt_pkg::pkt_info_t out_info
);

    rjfrt_pkg::pkt_info_t entries_reg [2];
    logic                 wr_ptr_reg;
    logic                 rd_ptr_reg;
    logic [1:0]           cnt_reg;
    logic [1:0]           cnt_next;
    logic                 push;
    logic                 pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_info  = entries_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // occupancy
    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= in_info;
        end
    end

    `RJFRT_ASSERT_IMP(a_cnt_range, aclk, aresetn, 1'b1, cnt_reg != 2'd3)
    `RJFRT_ASSERT_IMP(a_ptr_match, aclk, aresetn,
        (cnt_reg == 2'd0) || (cnt_reg == 2'd2), wr_ptr_reg == rd_ptr_reg)
    `RJFRT_ASSERT_NXT(a_fill, aclk, aresetn, push && !pop, cnt_reg == $past(cnt_reg) + 2'd1)

endmodule

// ===== rtl/rjfrt_back.sv =====
// back stage: frame tracking state and the result register
// depends on rjfrt_pkg and the assertion header
`include "rtp_jpeg_frame_reassembly_tracker_unit_assert.svh"
module rjfrt_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  rjfrt_pkg::pkt_info_t in_info,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [2:0]           m_status,
    output logic [23:0]          m_write_offset,
    output logic [11:0]          m_payload_bytes,
    output logic                 m_frame_end,
    output logic                 m_frame_complete,
    output logic [20:0]          m_frame_bytes
);

    // tracker state
    logic [16:0] count_reg, count_next;
    logic [15:0] first_seq_reg, first_seq_next;
    logic [31:0] frame_ts_reg, frame_ts_next;
    logic [20:0] total_reg, total_next;

    // result register
    logic               valid_reg;
    rjfrt_pkg::status_t status_reg, status_next;
    logic [23:0]        offset_reg, offset_next;
    logic [11:0]        pay_reg, pay_next;
    logic               end_reg, end_next;
    logic               complete_reg, complete_next;

    logic        fire;
    logic        opening;
    logic        go;
    logic        short_pkt;
    logic        ovf;
    logic [11:0] pay;
    logic [20:0] total_base;
    logic [15:0] first_eff;
    logic [16:0] count_inc;
    logic [21:0] sum;
    logic [16:0] span;

    assign in_ready = !valid_reg || m_ready;
    assign fire     = in_valid && in_ready;

    assign m_valid          = valid_reg;
    assign m_status         = status_reg;
    assign m_write_offset   = offset_reg;
    assign m_payload_bytes  = pay_reg;
    assign m_frame_end      = end_reg;
    assign m_frame_complete = complete_reg;
    assign m_frame_bytes    = total_reg;

    // frame tracking decision
    always_comb begin
        opening        = (count_reg == 17'd0);
        count_next     = count_reg;
        first_seq_next = first_seq_reg;
        frame_ts_next  = frame_ts_reg;
        total_next     = total_reg;
        status_next    = rjfrt_pkg::ST_ACCEPTED;
        offset_next    = 24'd0;
        pay_next       = 12'd0;
        end_next       = 1'b0;
        complete_next  = 1'b0;
        go             = 1'b0;
        short_pkt      = opening ? in_info.short_first : in_info.short_cont;
        ovf            = opening ? in_info.ovf_first : in_info.ovf_cont;
        pay            = opening ? in_info.pay_first : in_info.pay_cont;
        total_base     = opening ? 21'd0 : total_reg;
        first_eff      = opening ? in_info.seq_number : first_seq_reg;
        count_inc      = (count_reg == rjfrt_pkg::COUNT_MAX) ? count_reg :
                         count_reg + 17'd1;
        sum            = {1'b0, total_base} + {10'b0, pay};
        span           = {1'b0, in_info.seq_number - first_eff} + 17'd1;

        // frame search or timestamp check
        if (opening) begin
            if (in_info.off_nonzero) begin
                status_next = rjfrt_pkg::ST_NOT_FIRST;
            end else if (in_info.table_long) begin
                status_next = rjfrt_pkg::ST_TABLE_LONG;
            end else begin
                first_seq_next = in_info.seq_number;
                frame_ts_next  = in_info.rtp_timestamp;
                total_next     = 21'd0;
                go             = 1'b1;
            end
        end else if (in_info.rtp_timestamp != frame_ts_reg) begin
            count_next  = 17'd0;
            status_next = rjfrt_pkg::ST_TS_MISMATCH;
        end else begin
            go = 1'b1;
        end

        // payload checks and accounting
        if (go) begin
            if (in_info.not_jpeg) begin
                status_next = rjfrt_pkg::ST_NOT_JPEG;
            end else if (short_pkt) begin
                status_next = rjfrt_pkg::ST_TOO_SHORT;
            end else if (ovf) begin
                count_next  = 17'd0;
                total_next  = 21'd0;
                status_next = rjfrt_pkg::ST_OVERFLOW;
            end else begin
                total_next  = sum[21] ? rjfrt_pkg::TOTAL_MAX : sum[20:0];
                offset_next = in_info.frag_offset;
                pay_next    = pay;
                if (in_info.marker) begin
                    end_next      = 1'b1;
                    complete_next = (count_inc == span);
                    count_next    = 17'd0;
                end else begin
                    count_next = count_inc;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= 1'b0;
            count_reg     <= 17'd0;
            first_seq_reg <= 16'd0;
            frame_ts_reg  <= 32'd0;
            total_reg     <= 21'd0;
        end else begin
            if (in_ready) begin
                valid_reg <= in_valid;
            end
            if (fire) begin
                count_reg     <= count_next;
                first_seq_reg <= first_seq_next;
                frame_ts_reg  <= frame_ts_next;
                total_reg     <= total_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            status_reg   <= status_next;
            offset_reg   <= offset_next;
            pay_reg      <= pay_next;
            end_reg      <= end_next;
            complete_reg <= complete_next;
        end
    end

    `RJFRT_ASSERT_IMP(a_complete_needs_end, aclk, aresetn,
        valid_reg && complete_reg, end_reg)
    `RJFRT_ASSERT_IMP(a_reject_clean, aclk, aresetn,
        valid_reg && (status_reg != rjfrt_pkg::ST_ACCEPTED),
        (offset_reg == 24'd0) && (pay_reg == 12'd0) && !end_reg)
    `RJFRT_ASSERT_NXT(a_end_closes, aclk, aresetn,
        fire && end_next, count_reg == 17'd0)

endmodule

// ===== rtl/rtp_jpeg_frame_reassembly_tracker_unit.sv =====
// rtp/jpeg frame tracker: top level joining front stage, queue and back stage
// depends on rjfrt_pkg, rjfrt_front, rjfrt_queue and rjfrt_back
//
// usage:
//   s_* channel takes one parsed rtp/jpeg packet header word per cycle while
//   s_ready is high (valid/ready). m_* channel returns exactly one result word per packet,
//   in order: status, body write offset, payload length, frame end/complete
//   flags and the running body byte total of the open frame.
// path: a word accepted on s_* passes the input register, the queue and the
//   result register, in that order, before its result shows on m_*.
// throughput: one word per cycle while m_ready does not stall; the back stage
//   folds one word into the tracker state each cycle, and that state update sets it.
// stall: a stalled m_ready holds the result; the two-entry queue and the
//   input register keep s_ready high for up to three more words.
// reset: aresetn (synchronous, active low) empties all stages and clears
//   packet count, first sequence number, frame timestamp and byte total.
module rtp_jpeg_frame_reassembly_tracker_unit #(
    parameter int FRAME_BUFFER_BYTES = rjfrt_pkg::FRAME_BUFFER_BYTES_DEF,
    parameter int MAX_PACKET_BYTES   = rjfrt_pkg::MAX_PACKET_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [23:0] s_frag_offset,
    input  logic [7:0]  s_quality,
    input  logic [15:0] s_table_length,
    input  logic [15:0] s_seq_number,
    input  logic [31:0] s_rtp_timestamp,
    input  logic [6:0]  s_payload_type,
    input  logic        s_marker,
    input  logic [11:0] s_packet_len,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [23:0] m_write_offset,
    output logic [11:0] m_payload_bytes,
    output logic        m_frame_end,
    output logic        m_frame_complete,
    output logic [20:0] m_frame_bytes
);

    logic                 f_valid, f_ready;
    rjfrt_pkg::pkt_info_t f_info;
    logic                 q_valid, q_ready;
    rjfrt_pkg::pkt_info_t q_info;

    // classify
    rjfrt_front #(
        .FRAME_BUFFER_BYTES(FRAME_BUFFER_BYTES),
        .MAX_PACKET_BYTES  (MAX_PACKET_BYTES)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_frag_offset  (s_frag_offset),
        .s_quality      (s_quality),
        .s_table_length (s_table_length),
        .s_seq_number   (s_seq_number),
        .s_rtp_timestamp(s_rtp_timestamp),
        .s_payload_type (s_payload_type),
        .s_marker       (s_marker),
        .s_packet_len   (s_packet_len),
        .out_valid      (f_valid),
        .out_ready      (f_ready),
        .out_info       (f_info)
    );

    // decoupling queue
    rjfrt_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (f_valid),
        .in_ready (f_ready),
        .in_info  (f_info),
        .out_valid(q_valid),
        .out_ready(q_ready),
        .out_info (q_info)
    );

    // track frame state
    rjfrt_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (q_valid),
        .in_ready        (q_ready),
        .in_info         (q_info),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_write_offset  (m_write_offset),
        .m_payload_bytes (m_payload_bytes),
        .m_frame_end     (m_frame_end),
        .m_frame_complete(m_frame_complete),
        .m_frame_bytes   (m_frame_bytes)
    );

endmodule
